FILE: sv/assert_macros.svh
// Assertion helpers used by cartesian_to_spherical_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define C2S_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication form: whenever ante holds, cons must hold in the same cycle.
`define C2S_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `C2S_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: sv/c2s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_pkg
// Constants and types shared by the Cartesian-to-spherical converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

    // Angles are binary fractions of a turn, 2^32 counts per turn
    typedef logic [31:0] t_angle;

    // Fraction bits carried by the coordinates inside the CORDIC datapath
    localparam int GUARD_BITS = 10;

    // Most stages the arctangent table supports
    localparam int MAX_STAGES = 24;

    // CORDIC gain compensation factor, 1/1.6468 in Q0.32
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

    // Rounding offset for the final 16-bit shift of the gain product
    localparam logic [31:0] GAIN_ROUND = 32'h0000_8000;

    // Start angle for points in the left half-plane
    localparam t_angle HALF_TURN = 32'h8000_0000;

    // Elevation clamp, one quarter turn
    localparam logic signed [31:0] QUARTER_TURN = 32'sh4000_0000;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest
    localparam t_angle ATAN_TURNS [MAX_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage
`default_nettype wire

FILE: sv/c2s_point_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_point_if
// Request channel carrying one Cartesian point (x, y, z).
// ----------------------------------------------------------------------------
interface c2s_point_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                    output ready);
endinterface
`default_nettype wire

FILE: sv/c2s_sph_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_sph_if
// Result channel carrying one spherical result (range, azimuth, elevation).
// ----------------------------------------------------------------------------
interface c2s_sph_if #(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic        [COORD_WIDTH-1:0] range_out;
    logic        [ANGLE_WIDTH-1:0] azimuth;
    logic signed [ANGLE_WIDTH-1:0] elevation;

    modport source (output valid, output range_out, output azimuth, output elevation,
                    input ready);
    modport sink   (input valid, input range_out, input azimuth, input elevation,
                    output ready);
endinterface
`default_nettype wire

FILE: sv/cartesian_to_spherical_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_to_spherical_unit
// Converts a stream of 3-D points into range, azimuth and elevation using two
// chains of CORDIC vectoring cells with gain compensation after each.
// ----------------------------------------------------------------------------
// Usage:
//   i_point carries one point (x_coord, y_coord, z_coord) per request; o_sph
//   returns exactly one (range_out, azimuth, elevation) per point, in order.
//   Both channels transfer on a clock edge with valid and ready high.
//   From request to result a point passes one input stage, two rows of
//   CORDIC_STAGES cells, two two-stage gain multipliers and an output
//   rounding stage. Throughput is one point per clock while the receiver is
//   ready; every cell of the rows holds one point and hands it to its
//   neighbor whenever the stage after it can take it.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling empty slots, so i_point.ready stays high
//   until every stage holds a point; it then follows o_sph.ready.
//   A synchronous low i_rst_n empties the pipeline (all valid bits clear);
//   no result is pending after reset.
//   The origin yields all zeros; range saturates at 2^COORD_WIDTH - 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cartesian_to_spherical_unit #(
    parameter int COORD_WIDTH   = 24,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    c2s_point_if.sink    i_point,
    c2s_sph_if.source    o_sph
);

    localparam int GB    = c2s_pkg::GUARD_BITS;
    localparam int W     = COORD_WIDTH + GB + 3;   // datapath width, with growth
    localparam int N     = CORDIC_STAGES;
    localparam int S1_W  = W + 1;                  // pass-one side: {z, flag}
    localparam int G1_W  = 32 + S1_W;              // {angle, z, flag}
    localparam int S2_W  = ANGLE_WIDTH + 1;        // pass-two side: {azimuth, flag}
    localparam int G2_W  = 32 + S2_W;              // {angle, azimuth, flag}
    localparam int RW    = W + 1;
    localparam int RI_W  = RW - GB;

    localparam c2s_pkg::t_angle AZ_RND = 32'd1 << (31 - ANGLE_WIDTH);
    localparam logic signed [32:0] EL_RND = 33'sd1 <<< (31 - ANGLE_WIDTH);
    localparam logic [RW-1:0] RANGE_RND = RW'(1) << (GB - 1);
    localparam logic signed [ANGLE_WIDTH-1:0] EL_MAX =
        ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
    localparam logic signed [ANGLE_WIDTH-1:0] EL_MIN = -EL_MAX;

    // ------------------------------------------------------------------
    // Input stage: scale, fold left half-plane, flag horizontal origin
    // ------------------------------------------------------------------
    logic                 w_pre_adv;
    logic                 r_pre_valid;
    logic signed [W-1:0]  n_pre_x, n_pre_y, n_pre_z;
    logic signed [W-1:0]  r_pre_x, r_pre_y, r_pre_z;
    c2s_pkg::t_angle      n_pre_ang, r_pre_ang;
    logic                 n_pre_flag, r_pre_flag;

    logic signed [W-1:0]  w_p1_x    [N+1];
    logic signed [W-1:0]  w_p1_y    [N+1];
    c2s_pkg::t_angle      w_p1_ang  [N+1];
    logic [S1_W-1:0]      w_p1_side [N+1];
    logic                 w_p1_valid[N+1];
    logic                 w_p1_ready[N+1];

    assign w_pre_adv     = !r_pre_valid || w_p1_ready[0];
    assign i_point.ready = w_pre_adv;

    always_comb begin
        n_pre_x    = {{(W-COORD_WIDTH-GB){i_point.x_coord[COORD_WIDTH-1]}},
                      i_point.x_coord, {GB{1'b0}}};
        n_pre_y    = {{(W-COORD_WIDTH-GB){i_point.y_coord[COORD_WIDTH-1]}},
                      i_point.y_coord, {GB{1'b0}}};
        n_pre_z    = {{(W-COORD_WIDTH-GB){i_point.z_coord[COORD_WIDTH-1]}},
                      i_point.z_coord, {GB{1'b0}}};
        n_pre_ang  = '0;
        n_pre_flag = (i_point.x_coord != '0) || (i_point.y_coord != '0);
        if (i_point.x_coord[COORD_WIDTH-1]) begin
            n_pre_x   = -n_pre_x;
            n_pre_y   = -n_pre_y;
            n_pre_ang = c2s_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (w_pre_adv) begin
            r_pre_valid <= i_point.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pre_adv && i_point.valid) begin
            r_pre_x    <= n_pre_x;
            r_pre_y    <= n_pre_y;
            r_pre_z    <= n_pre_z;
            r_pre_ang  <= n_pre_ang;
            r_pre_flag <= n_pre_flag;
        end
    end

    // ------------------------------------------------------------------
    // Pass one: (x, y) -> horizontal magnitude and azimuth
    // ------------------------------------------------------------------
    assign w_p1_valid[0] = r_pre_valid;
    assign w_p1_x[0]     = r_pre_x;
    assign w_p1_y[0]     = r_pre_y;
    assign w_p1_ang[0]   = r_pre_ang;
    assign w_p1_side[0]  = {r_pre_z, r_pre_flag};

    for (genvar gi = 0; gi < N; gi++) begin : g_pass1
        c2s_cordic_cell #(
            .W      (W),
            .STAGE  (gi),
            .SIDE_W (S1_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_p1_valid[gi]),
            .o_ready (w_p1_ready[gi]),
            .i_x     (w_p1_x[gi]),
            .i_y     (w_p1_y[gi]),
            .i_ang   (w_p1_ang[gi]),
            .i_side  (w_p1_side[gi]),
            .o_valid (w_p1_valid[gi+1]),
            .i_ready (w_p1_ready[gi+1]),
            .o_x     (w_p1_x[gi+1]),
            .o_y     (w_p1_y[gi+1]),
            .o_ang   (w_p1_ang[gi+1]),
            .o_side  (w_p1_side[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Gain compensation after pass one
    // ------------------------------------------------------------------
    logic                 w_g1_valid, w_g1_ready;
    logic signed [W-1:0]  w_g1_v;
    logic [G1_W-1:0]      w_g1_side;

    c2s_gain #(
        .W      (W),
        .SIDE_W (G1_W)
    ) u_gain1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_p1_valid[N]),
        .o_ready (w_p1_ready[N]),
        .i_v     (w_p1_x[N]),
        .i_side  ({w_p1_ang[N], w_p1_side[N]}),
        .o_valid (w_g1_valid),
        .i_ready (w_g1_ready),
        .o_v     (w_g1_v),
        .o_side  (w_g1_side)
    );

    // select results of pass one; skipped pass reads as zero
    logic                 w_g1_flag, w_p2_flag;
    c2s_pkg::t_angle      w_g1_ang, w_az_sum;
    logic signed [W-1:0]  w_g1_z, w_horiz;
    logic [ANGLE_WIDTH-1:0] w_az;

    assign w_g1_flag = w_g1_side[0];
    assign w_g1_z    = w_g1_side[W:1];
    assign w_g1_ang  = w_g1_side[G1_W-1 -: 32];
    assign w_horiz   = w_g1_flag ? w_g1_v : '0;
    assign w_az_sum  = w_g1_ang + AZ_RND;
    assign w_az      = w_g1_flag ? w_az_sum[31 -: ANGLE_WIDTH] : '0;
    assign w_p2_flag = (w_horiz != '0) || (w_g1_z != '0);

    // ------------------------------------------------------------------
    // Pass two: (horizontal, z) -> range and elevation
    // ------------------------------------------------------------------
    logic signed [W-1:0]  w_p2_x    [N+1];
    logic signed [W-1:0]  w_p2_y    [N+1];
    c2s_pkg::t_angle      w_p2_ang  [N+1];
    logic [S2_W-1:0]      w_p2_side [N+1];
    logic                 w_p2_valid[N+1];
    logic                 w_p2_ready[N+1];

    assign w_p2_valid[0] = w_g1_valid;
    assign w_g1_ready    = w_p2_ready[0];
    assign w_p2_x[0]     = w_horiz;
    assign w_p2_y[0]     = w_g1_z;
    assign w_p2_ang[0]   = '0;
    assign w_p2_side[0]  = {w_az, w_p2_flag};

    for (genvar gj = 0; gj < N; gj++) begin : g_pass2
        c2s_cordic_cell #(
            .W      (W),
            .STAGE  (gj),
            .SIDE_W (S2_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_p2_valid[gj]),
            .o_ready (w_p2_ready[gj]),
            .i_x     (w_p2_x[gj]),
            .i_y     (w_p2_y[gj]),
            .i_ang   (w_p2_ang[gj]),
            .i_side  (w_p2_side[gj]),
            .o_valid (w_p2_valid[gj+1]),
            .i_ready (w_p2_ready[gj+1]),
            .o_x     (w_p2_x[gj+1]),
            .o_y     (w_p2_y[gj+1]),
            .o_ang   (w_p2_ang[gj+1]),
            .o_side  (w_p2_side[gj+1])
        );
    end

    // ------------------------------------------------------------------
    // Gain compensation after pass two
    // ------------------------------------------------------------------
    logic                 w_g2_valid, w_g2_ready;
    logic signed [W-1:0]  w_g2_v;
    logic [G2_W-1:0]      w_g2_side;

    c2s_gain #(
        .W      (W),
        .SIDE_W (G2_W)
    ) u_gain2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_p2_valid[N]),
        .o_ready (w_p2_ready[N]),
        .i_v     (w_p2_x[N]),
        .i_side  ({w_p2_ang[N], w_p2_side[N]}),
        .o_valid (w_g2_valid),
        .i_ready (w_g2_ready),
        .o_v     (w_g2_v),
        .o_side  (w_g2_side)
    );

    // ------------------------------------------------------------------
    // Output stage: range rounding and saturation, elevation rounding and clamp
    // ------------------------------------------------------------------
    logic                       w_out_adv;
    logic                       r_out_valid;
    logic                       w_g2_flag;
    logic signed [31:0]         w_el_raw, w_el_clip;
    logic signed [32:0]         w_el_sum, w_el_shift;
    logic [W-1:0]               w_range_c;
    logic [RW-1:0]              w_range_sum;
    logic [RI_W-1:0]            w_range_int;
    logic [COORD_WIDTH-1:0]     n_range;
    logic [COORD_WIDTH-1:0]     r_range;
    logic [ANGLE_WIDTH-1:0]     r_az;
    logic signed [ANGLE_WIDTH-1:0] r_el;

    assign w_out_adv  = !r_out_valid || o_sph.ready;
    assign w_g2_ready = w_out_adv;

    assign w_g2_flag = w_g2_side[0];
    assign w_el_raw  = w_g2_flag ? signed'(w_g2_side[G2_W-1 -: 32]) : '0;

    always_comb begin
        priority if (w_el_raw > c2s_pkg::QUARTER_TURN) begin
            w_el_clip = c2s_pkg::QUARTER_TURN;
        end else if (w_el_raw < -c2s_pkg::QUARTER_TURN) begin
            w_el_clip = -c2s_pkg::QUARTER_TURN;
        end else begin
            w_el_clip = w_el_raw;
        end
    end

    assign w_el_sum   = {w_el_clip[31], w_el_clip} + EL_RND;
    assign w_el_shift = w_el_sum >>> (32 - ANGLE_WIDTH);

    assign w_range_c   = w_g2_flag ? w_g2_v : '0;
    assign w_range_sum = RW'(w_range_c) + RANGE_RND;
    assign w_range_int = w_range_sum[RW-1:GB];
    assign n_range     = (w_range_int[RI_W-1:COORD_WIDTH] != '0) ? '1
                                                               : w_range_int[COORD_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= w_g2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && w_g2_valid) begin
            r_range <= n_range;
            r_az    <= w_g2_side[S2_W-1:1];
            r_el    <= w_el_shift[ANGLE_WIDTH-1:0];
        end
    end

    assign o_sph.valid     = r_out_valid;
    assign o_sph.range_out = r_range;
    assign o_sph.azimuth   = r_az;
    assign o_sph.elevation = r_el;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // left half-plane fold leaves a non-negative x
    `C2S_ASSERT_IMPL(a_pre_x_nonneg, i_clk, i_rst_n, r_pre_valid, !r_pre_x[W-1],
        "input stage holds a negative x after folding")
    // pass one ends with a non-negative magnitude
    `C2S_ASSERT_IMPL(a_p1_mag_nonneg, i_clk, i_rst_n, w_p1_valid[N] && w_p1_side[N][0],
        !w_p1_x[N][W-1], "pass one produced a negative magnitude")
    // elevation stays within a quarter turn
    `C2S_ASSERT_IMPL(a_el_bound, i_clk, i_rst_n, o_sph.valid,
        (o_sph.elevation <= EL_MAX) && (o_sph.elevation >= EL_MIN),
        "elevation beyond a quarter turn")

endmodule
`default_nettype wire

FILE: sv/c2s_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_cordic_cell
// One CORDIC vectoring micro-rotation with its own pipeline register and
// valid/ready handshake. Side data rides along unchanged.
// ----------------------------------------------------------------------------
module c2s_cordic_cell #(
    parameter int W      = 37,
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // upstream
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic signed [W-1:0]   i_x,
    input  wire logic signed [W-1:0]   i_y,
    input  wire c2s_pkg::t_angle       i_ang,
    input  wire logic [SIDE_W-1:0]     i_side,
    // downstream
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [W-1:0]        o_x,
    output logic signed [W-1:0]        o_y,
    output c2s_pkg::t_angle            o_ang,
    output logic [SIDE_W-1:0]          o_side
);

    localparam c2s_pkg::t_angle ATAN_STEP = c2s_pkg::ATAN_TURNS[STAGE];

    logic                 w_adv;
    logic                 r_valid;
    logic signed [W-1:0]  r_x, r_y;
    logic signed [W-1:0]  n_x, n_y;
    logic signed [W-1:0]  w_xs, w_ys;
    c2s_pkg::t_angle      r_ang, n_ang;
    logic [SIDE_W-1:0]    r_side;

    // stage moves when empty or when its content is taken
    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;

    // micro-rotation toward the positive x axis (floor shifts)
    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;

    always_comb begin
        if (!i_y[W-1]) begin
            n_x   = i_x + w_ys;
            n_y   = i_y - w_xs;
            n_ang = i_ang + ATAN_STEP;
        end else begin
            n_x   = i_x - w_ys;
            n_y   = i_y + w_xs;
            n_ang = i_ang - ATAN_STEP;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_ang  <= n_ang;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_ang   = r_ang;
    assign o_side  = r_side;

endmodule
`default_nettype wire

FILE: sv/c2s_gain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2s_gain
// Two-stage CORDIC gain compensation: multiplies a non-negative magnitude by
// GAIN_Q32 using a 16-bit split, then adds and rounds. Side data rides along.
// ----------------------------------------------------------------------------
module c2s_gain #(
    parameter int W      = 37,
    parameter int SIDE_W = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // upstream
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic signed [W-1:0]   i_v,
    input  wire logic [SIDE_W-1:0]     i_side,
    // downstream
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [W-1:0]        o_v,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int HI_W  = W - 17;       // magnitude bits above the low 16
    localparam int HP_W  = HI_W + 32;    // high partial product
    localparam int SUM_W = HP_W + 1;

    logic               w_a_adv, w_b_adv;
    logic               r_a_valid, r_b_valid;
    logic [HI_W-1:0]    w_u_hi;
    logic [15:0]        w_u_lo;
    logic [HP_W-1:0]    n_hi, r_hi;
    logic [47:0]        w_lo_full;
    logic [31:0]        r_lo;
    logic [SUM_W-1:0]   w_sum;
    logic signed [W-1:0] r_v;
    logic [SIDE_W-1:0]  r_a_side, r_b_side;

    assign w_b_adv = !r_b_valid || i_ready;
    assign w_a_adv = !r_a_valid || w_b_adv;
    assign o_ready = w_a_adv;

    // negative magnitudes count as zero
    assign w_u_hi = i_v[W-1] ? '0 : i_v[W-2:16];
    assign w_u_lo = i_v[W-1] ? '0 : i_v[15:0];

    // partial products
    assign n_hi      = HP_W'(w_u_hi) * HP_W'(c2s_pkg::GAIN_Q32);
    assign w_lo_full = 48'(w_u_lo) * 48'(c2s_pkg::GAIN_Q32);

    // sum with rounding
    assign w_sum = SUM_W'(r_hi) + SUM_W'(r_lo) + SUM_W'(c2s_pkg::GAIN_ROUND);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_adv) begin
                r_a_valid <= i_valid;
            end
            if (w_b_adv) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_a_adv && i_valid) begin
            r_hi     <= n_hi;
            r_lo     <= w_lo_full[47:16];
            r_a_side <= i_side;
        end
        if (w_b_adv && r_a_valid) begin
            r_v      <= w_sum[16 +: W];
            r_b_side <= r_a_side;
        end
    end

    assign o_valid = r_b_valid;
    assign o_v     = r_v;
    assign o_side  = r_b_side;

endmodule
`default_nettype wire
